// ===== hdl/fskiq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the quarter-wave sine table of the FSK I/Q generator.
// No dependencies; every other file but fskiq_ram imports this package.
package fskiq_pkg;

  // Table and fixed-point sizing
  localparam int TABLE_ADDR_BITS = 10;
  localparam int AMP_FRAC_BITS   = 14;
  localparam int TBL_N           = 1 << TABLE_ADDR_BITS;
  localparam int TBL_DEPTH       = TBL_N + 1;
  localparam int TBL_AW          = TABLE_ADDR_BITS + 1;
  localparam int SAMP_W          = AMP_FRAC_BITS + 1;

  // Noise generator reset and fallback seed
  localparam logic [31:0] SEED_DEFAULT = 32'd2463534242;

  // Request queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // Configuration port
  localparam int PADDR_W   = 5;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_STEP_ZERO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_STEP_ONE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_NOISE_AMP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_NOISE_AMP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_SEED     = 3'd5;

  // Symbol kinds
  localparam logic [1:0] KIND_GAP  = 2'd0;
  localparam logic [1:0] KIND_ZERO = 2'd1;
  localparam logic [1:0] KIND_ONE  = 2'd2;

  typedef struct packed {
    logic [1:0] symbol_kind;
    logic       restart;
  } sample_t;

  typedef struct packed {
    logic [7:0] i_byte;
    logic [7:0] q_byte;
  } iq_t;

  // Register file contents plus the seed load strobe
  typedef struct packed {
    logic [31:0] tone_step_zero;
    logic [31:0] tone_step_one;
    logic [15:0] gap_noise_amp;
    logic [15:0] tone_noise_amp;
    logic [15:0] output_gain;
    logic        seed_load;
    logic [31:0] seed_value;
  } cfg_t;

  // One classified request waiting for the back end
  typedef struct packed {
    logic        tone;
    logic [31:0] phase;
    logic [31:0] noise;
    logic [15:0] amp;
  } q_entry_t;

  typedef logic [SAMP_W-1:0] tbl_t [TBL_DEPTH];

  // Quarter-wave sine by Taylor series in Q30, rounded to AMP_FRAC_BITS
  function automatic tbl_t build_table();
    tbl_t        t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] r;
    for (int k = 0; k < TBL_DEPTH; k++) begin
      x    = (64'(k) * 64'd1686629713) >> TABLE_ADDR_BITS;
      x2   = (x * x) >> 30;
      sum  = x;
      term = x;
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if ((n % 2) == 1) begin
          sum = (sum >= term) ? sum - term : 64'd0;
        end else begin
          sum = sum + term;
        end
      end
      r = (sum + (64'd1 << (29 - AMP_FRAC_BITS))) >> (30 - AMP_FRAC_BITS);
      if (r > (64'd1 << AMP_FRAC_BITS)) begin
        r = 64'd1 << AMP_FRAC_BITS;
      end
      t[k] = r[SAMP_W-1:0];
    end
    return t;
  endfunction

  localparam tbl_t QTBL = build_table();

endpackage

// ===== hdl/fskiq_ram.sv =====
`timescale 1ns / 1ps
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module fskiq_ram #(
  parameter int  WIDTH = 16,
  parameter int  DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register both reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== hdl/fskiq_cfg.sv =====
`timescale 1ns / 1ps
// APB-style register file for step, amplitude, gain and seed settings.
// Depends on fskiq_pkg.
module fskiq_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fskiq_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output fskiq_pkg::cfg_t               cfg
);
  import fskiq_pkg::*;

  logic [31:0]          tone_step_zero;
  logic [31:0]          tone_step_one;
  logic [15:0]          gap_noise_amp;
  logic [15:0]          tone_noise_amp;
  logic [15:0]          output_gain;
  logic [31:0]          noise_seed;
  logic                 wr;
  logic [CFG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[PADDR_W-1:2];

  // Write registers; addresses beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      tone_step_zero <= 32'd53687;
      tone_step_one  <= 32'd536871;
      gap_noise_amp  <= 16'd6554;
      tone_noise_amp <= 16'd3277;
      output_gain    <= 16'd4096;
      noise_seed     <= SEED_DEFAULT;
    end else if (wr) begin
      unique case (idx)
        REG_TONE_STEP_ZERO: tone_step_zero <= pwdata;
        REG_TONE_STEP_ONE:  tone_step_one  <= pwdata;
        REG_GAP_NOISE_AMP:  gap_noise_amp  <= pwdata[15:0];
        REG_TONE_NOISE_AMP: tone_noise_amp <= pwdata[15:0];
        REG_OUTPUT_GAIN:    output_gain    <= pwdata[15:0];
        REG_NOISE_SEED:     noise_seed     <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_TONE_STEP_ZERO: prdata = tone_step_zero;
      REG_TONE_STEP_ONE:  prdata = tone_step_one;
      REG_GAP_NOISE_AMP:  prdata = {16'd0, gap_noise_amp};
      REG_TONE_NOISE_AMP: prdata = {16'd0, tone_noise_amp};
      REG_OUTPUT_GAIN:    prdata = {16'd0, output_gain};
      REG_NOISE_SEED:     prdata = noise_seed;
      default:            prdata = 32'd0;
    endcase
  end

  // Hand settings and the seed load strobe to the datapath
  always_comb begin
    cfg.tone_step_zero = tone_step_zero;
    cfg.tone_step_one  = tone_step_one;
    cfg.gap_noise_amp  = gap_noise_amp;
    cfg.tone_noise_amp = tone_noise_amp;
    cfg.output_gain    = output_gain;
    cfg.seed_load      = wr && (idx == REG_NOISE_SEED);
    cfg.seed_value     = pwdata;
  end

endmodule

// ===== hdl/fskiq_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts sample requests, steps the noise generator and phase
// accumulator, and pushes a classified entry. Depends on fskiq_pkg.
module fskiq_front (
  input  logic                 clk,
  input  logic                 rst,
  input  fskiq_pkg::cfg_t      cfg,
  input  logic                 sample_valid,
  input  fskiq_pkg::sample_t   sample,
  output logic                 sample_stall,
  input  logic                 q_full,
  input  logic                 busy,
  output logic                 push,
  output fskiq_pkg::q_entry_t  entry
);
  import fskiq_pkg::*;

  logic [31:0] phase_acc;
  logic [31:0] noise_state;
  logic [31:0] s1;
  logic [31:0] s2;
  logic [31:0] s3;
  logic [31:0] phase_base;
  logic [31:0] step;
  logic        tone;

  assign sample_stall = busy || q_full;
  assign push         = sample_valid && !sample_stall;

  // Classify the request and step xorshift32
  always_comb begin
    s1 = noise_state ^ (noise_state << 13);
    s2 = s1 ^ (s1 >> 17);
    s3 = s2 ^ (s2 << 5);
    phase_base = sample.restart ? 32'd0 : phase_acc;
    case (sample.symbol_kind)
      KIND_ZERO: tone = 1'b1;
      KIND_ONE:  tone = 1'b1;
      default:   tone = 1'b0;
    endcase
    step = (sample.symbol_kind == KIND_ONE) ? cfg.tone_step_one : cfg.tone_step_zero;
    entry.tone  = tone;
    entry.phase = phase_base;
    entry.noise = s3;
    entry.amp   = tone ? cfg.tone_noise_amp : cfg.gap_noise_amp;
  end

  // Advance phase on tones only; a seed write reloads the generator
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc   <= 32'd0;
      noise_state <= SEED_DEFAULT;
    end else begin
      if (cfg.seed_load) begin
        noise_state <= (cfg.seed_value == 32'd0) ? SEED_DEFAULT : cfg.seed_value;
      end else if (push) begin
        noise_state <= s3;
      end
      if (push) begin
        phase_acc <= tone ? phase_base + step : phase_base;
      end
    end
  end

endmodule

// ===== hdl/fskiq_queue.sv =====
`timescale 1ns / 1ps
// Short request queue between the front and back ends.
// Depends on fskiq_pkg.
module fskiq_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  fskiq_pkg::q_entry_t  push_entry,
  input  logic                 pop,
  output fskiq_pkg::q_entry_t  head,
  output logic                 empty,
  output logic                 full
);
  import fskiq_pkg::*;

  q_entry_t          entries [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr;
  logic [Q_AW-1:0]   rd_ptr;
  logic [Q_AW:0]     count;

  assign empty = (count == '0);
  assign full  = (count == (Q_AW + 1)'(Q_DEPTH));
  assign head  = entries[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/fskiq_back.sv =====
`timescale 1ns / 1ps
// Back end: table fill after reset, sine/cosine lookup, noise scaling,
// gain and byte quantisation, output register. Depends on fskiq_pkg, fskiq_ram.
module fskiq_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [15:0]          output_gain,
  input  logic                 q_empty,
  input  fskiq_pkg::q_entry_t  head,
  output logic                 pop,
  output logic                 busy,
  output logic                 iq_valid,
  input  logic                 iq_stall,
  output fskiq_pkg::iq_t       iq
);
  import fskiq_pkg::*;

  localparam int NSHIFT  = 31 - AMP_FRAC_BITS;
  localparam int SUM_W   = AMP_FRAC_BITS + 4;
  localparam int VW      = SUM_W - 1;
  localparam int P1W     = VW + 16;
  localparam int P2W     = P1W + 8;
  localparam int BSHIFT  = AMP_FRAC_BITS + 13;
  localparam int HIW     = P2W - BSHIFT;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SUM  = 4'b0010,
    ST_GAIN = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // Table fill sweep
  logic              fill_active;
  logic [TBL_AW-1:0] fill_addr;

  // Lookup addressing
  logic [1:0]              sin_quad;
  logic [1:0]              cos_quad;
  logic [TABLE_ADDR_BITS-1:0] idx;
  logic [TBL_AW-1:0]       sin_addr;
  logic [TBL_AW-1:0]       cos_addr;
  logic [SAMP_W-1:0]       sin_mag;
  logic [SAMP_W-1:0]       cos_mag;

  // Datapath registers
  logic                    tone;
  logic                    sin_neg;
  logic                    cos_neg;
  logic signed [32:0]      prod_i;
  logic signed [32:0]      prod_q;
  logic [VW-1:0]           vclip_i;
  logic [VW-1:0]           vclip_q;
  logic [P1W-1:0]          p1_i;
  logic [P1W-1:0]          p1_q;

  // Combinational intermediates
  logic signed [SUM_W-1:0] noise_i;
  logic signed [SUM_W-1:0] noise_q;
  logic signed [SUM_W-1:0] tone_i;
  logic signed [SUM_W-1:0] tone_q;
  logic signed [SUM_W-1:0] v_i;
  logic signed [SUM_W-1:0] v_q;
  logic [P2W-1:0]          p2_i;
  logic [P2W-1:0]          p2_q;
  logic [HIW-1:0]          hi_i;
  logic [HIW-1:0]          hi_q;
  logic [7:0]              byte_i;
  logic [7:0]              byte_q;
  logic                    out_free;

  assign busy     = fill_active;
  assign pop      = (state == ST_IDLE) && !q_empty && !fill_active;
  assign out_free = !iq_valid || !iq_stall;

  // Fill the quarter-wave table once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_active <= 1'b1;
      fill_addr   <= '0;
    end else if (fill_active) begin
      if (fill_addr == TBL_AW'(TBL_N)) begin
        fill_active <= 1'b0;
      end else begin
        fill_addr <= fill_addr + 1'b1;
      end
    end
  end

  // Fold the phase onto the quarter wave; cosine is a quarter turn ahead
  always_comb begin
    sin_quad = head.phase[31:30];
    cos_quad = head.phase[31:30] + 2'd1;
    idx      = head.phase[29 -: TABLE_ADDR_BITS];
    sin_addr = sin_quad[0] ? TBL_AW'(TBL_N) - {1'b0, idx} : {1'b0, idx};
    cos_addr = cos_quad[0] ? TBL_AW'(TBL_N) - {1'b0, idx} : {1'b0, idx};
  end

  fskiq_ram #(
    .WIDTH (SAMP_W),
    .DEPTH (TBL_DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (fill_active),
    .waddr   (fill_addr),
    .wdata   (QTBL[fill_addr]),
    .raddr_a (cos_addr),
    .raddr_b (sin_addr),
    .rdata_a (cos_mag),
    .rdata_b (sin_mag)
  );

  // Sequence one request at a time
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (pop) state_next = ST_SUM;
      ST_SUM:  state_next = ST_GAIN;
      ST_GAIN: state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sum noise and tone, offset by one, clip at zero
  always_comb begin
    noise_i = SUM_W'(prod_i >>> NSHIFT);
    noise_q = SUM_W'(prod_q >>> NSHIFT);
    tone_i  = '0;
    tone_q  = '0;
    if (tone) begin
      tone_i = cos_neg ? -$signed(SUM_W'(cos_mag)) : $signed(SUM_W'(cos_mag));
      tone_q = sin_neg ? -$signed(SUM_W'(sin_mag)) : $signed(SUM_W'(sin_mag));
    end
    v_i = noise_i + tone_i + $signed(SUM_W'(1) <<< AMP_FRAC_BITS);
    v_q = noise_q + tone_q + $signed(SUM_W'(1) <<< AMP_FRAC_BITS);
  end

  // Times 255 as shift and subtract, then saturate to a byte
  always_comb begin
    p2_i   = {p1_i, 8'd0} - P2W'(p1_i);
    p2_q   = {p1_q, 8'd0} - P2W'(p1_q);
    hi_i   = p2_i[P2W-1:BSHIFT];
    hi_q   = p2_q[P2W-1:BSHIFT];
    byte_i = (|hi_i[HIW-1:8]) ? 8'hFF : hi_i[7:0];
    byte_q = (|hi_q[HIW-1:8]) ? 8'hFF : hi_q[7:0];
  end

  // Datapath registers, one step per state
  always_ff @(posedge clk) begin
    if (pop) begin
      tone    <= head.tone;
      sin_neg <= sin_quad[1];
      cos_neg <= cos_quad[1];
      prod_i  <= $signed(head.noise[31:16] ^ 16'h8000) * $signed({1'b0, head.amp});
      prod_q  <= $signed(head.noise[15:0] ^ 16'h8000) * $signed({1'b0, head.amp});
    end
    if (state == ST_SUM) begin
      vclip_i <= (v_i > 0) ? v_i[VW-1:0] : '0;
      vclip_q <= (v_q > 0) ? v_q[VW-1:0] : '0;
    end
    if (state == ST_GAIN) begin
      p1_i <= P1W'(vclip_i) * P1W'(output_gain);
      p1_q <= P1W'(vclip_q) * P1W'(output_gain);
    end
  end

  // Output register: load when free, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      iq_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      iq_valid <= 1'b1;
    end else if (!iq_stall) begin
      iq_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      iq.i_byte <= byte_i;
      iq.q_byte <= byte_q;
    end
  end

endmodule

// ===== hdl/fsk_iq_sample_generator.sv =====
`timescale 1ns / 1ps
// Binary FSK I/Q sample generator: NCO tones plus xorshift32 noise, as bytes.
// Path: an accepted request is queued, popped when the back end is idle, then passes
// ST_SUM and ST_GAIN to ST_DONE, which loads the output register and sets iq_valid. The
// back end takes one request at a time; a 4-entry queue lets requests be taken while a
// result waits on iq_stall. Reset: synchronous; the sine table is then filled, during
// which sample_stall is held high. Configuration writes are taken whenever rst is low.
module fsk_iq_sample_generator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  fskiq_pkg::sample_t            sample,
  output logic                          iq_valid,
  input  logic                          iq_stall,
  output fskiq_pkg::iq_t                iq,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fskiq_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import fskiq_pkg::*;

  cfg_t     cfg;
  q_entry_t push_entry;
  q_entry_t head;
  logic     push;
  logic     pop;
  logic     q_empty;
  logic     q_full;
  logic     busy;

  fskiq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fskiq_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample_valid (sample_valid),
    .sample       (sample),
    .sample_stall (sample_stall),
    .q_full       (q_full),
    .busy         (busy),
    .push         (push),
    .entry        (push_entry)
  );

  fskiq_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  fskiq_back u_back (
    .clk         (clk),
    .rst         (rst),
    .output_gain (cfg.output_gain),
    .q_empty     (q_empty),
    .head        (head),
    .pop         (pop),
    .busy        (busy),
    .iq_valid    (iq_valid),
    .iq_stall    (iq_stall),
    .iq          (iq)
  );

endmodule

// ===== hdl/fskiq_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the FSK I/Q generator, bound to the top level.
// Depends on fskiq_pkg and fsk_iq_sample_generator.
module fskiq_assert (
  input logic                          clk,
  input logic                          rst,
  input logic                          sample_valid,
  input logic                          sample_stall,
  input logic                          iq_valid,
  input logic                          iq_stall,
  input fskiq_pkg::iq_t                iq,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [fskiq_pkg::PADDR_W-1:0] paddr,
  input logic [31:0]                   pwdata,
  input logic [31:0]                   prdata,
  input logic                          pready
);
  import fskiq_pkg::*;

  // Hold a stalled result
  a_iq_hold: assert property (@(posedge clk) disable iff (rst)
    iq_valid && iq_stall |=> iq_valid)
    else $error("result dropped while stalled");

  a_iq_stable: assert property (@(posedge clk) disable iff (rst)
    iq_valid && iq_stall |=> $stable(iq))
    else $error("stalled result changed");

  // No request taken as reset is released, while the sine table is being filled
  a_fill_stall: assert property (@(posedge clk)
    !rst && $past(rst) |-> sample_stall && !(sample_valid && !sample_stall))
    else $error("request taken during table fill");

  // Tone step zero reads back what was written
  a_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready
      && (paddr[PADDR_W-1:2] == REG_TONE_STEP_ZERO)
    |=> (paddr[PADDR_W-1:2] != REG_TONE_STEP_ZERO) || (prdata == $past(pwdata)))
    else $error("register read-back mismatch");

endmodule

bind fsk_iq_sample_generator fskiq_assert u_checker (.*);

// ===== tb/sv/fskiq_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the FSK I/Q sample generator: follows the register port, predicts
// each I/Q pair from every accepted request and compares. Depends on fskiq_pkg.
module fskiq_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  input  logic                          sample_stall,
  input  fskiq_pkg::sample_t            sample,
  input  logic                          iq_valid,
  input  logic                          iq_stall,
  input  fskiq_pkg::iq_t                iq,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fskiq_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  input  logic [31:0]                   prdata,
  input  logic                          pready,
  output int                            mismatches,
  output int                            outstanding
);
  import fskiq_pkg::*;

  localparam int          ADDR_BITS     = 10;
  localparam int          FRAC          = 14;
  localparam int          QUARTER_N     = 1 << ADDR_BITS;
  localparam int          REPORT_MAX    = 10;
  localparam logic [31:0] FALLBACK_SEED = 32'd2463534242;
  localparam logic [31:0] QUARTER_TURN  = 32'h4000_0000;

  logic [15:0] quarter_sine [0:QUARTER_N];

  // Shadow registers and oscillator state
  logic [31:0] step_zero;
  logic [31:0] step_one;
  logic [31:0] seed_reg;
  logic [15:0] gap_amp;
  logic [15:0] tone_amp;
  logic [15:0] gain;
  logic [31:0] phase;
  logic [31:0] lfsr;

  iq_t pending_iq [$];
  int  fail_count = 0;

  // Build the quarter-wave sine by a truncated Taylor series in Q30
  initial begin : build_quarter
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] acc;
    logic [63:0] term;
    logic [63:0] r;
    for (int k = 0; k <= QUARTER_N; k++) begin
      x    = (64'(k) * 64'd1686629713) >> ADDR_BITS;
      x2   = (x * x) >> 30;
      acc  = x;
      term = x;
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = (acc >= term) ? acc - term : 64'd0;
        end else begin
          acc = acc + term;
        end
      end
      r = (acc + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
      if (r > (64'd1 << FRAC)) begin
        r = 64'd1 << FRAC;
      end
      quarter_sine[k] = r[15:0];
    end
  end

  function automatic longint sine_at(logic [31:0] p);
    logic [ADDR_BITS-1:0] idx;
    longint               mag;
    idx = p[29 -: ADDR_BITS];
    mag = p[30] ? quarter_sine[QUARTER_N - idx] : quarter_sine[idx];
    return p[31] ? -mag : mag;
  endfunction

  // Centre the noise half and scale it, flooring toward minus infinity
  function automatic longint noise_term(logic [15:0] u, logic [15:0] amp);
    longint n;
    n = longint'(u) - 64'sd32768;
    return (n * longint'(amp)) >>> (31 - FRAC);
  endfunction

  function automatic logic [7:0] quantise(longint x);
    longint      v;
    logic [63:0] p;
    v = x + (64'sd1 <<< FRAC);
    if (v <= 0) begin
      return 8'd0;
    end
    p = ($unsigned(v) * gain * 64'd255) >> (FRAC + 13);
    return (p > 64'd255) ? 8'd255 : p[7:0];
  endfunction

  // Step the noise generator and oscillator for one request
  function automatic iq_t next_iq(sample_t s);
    logic [31:0] x;
    logic        tone;
    logic [15:0] amp;
    longint      ci;
    longint      sq;
    iq_t         r;
    x    = lfsr;
    x    = x ^ (x << 13);
    x    = x ^ (x >> 17);
    x    = x ^ (x << 5);
    lfsr = x;
    if (s.restart) begin
      phase = '0;
    end
    tone = (s.symbol_kind == KIND_ZERO) || (s.symbol_kind == KIND_ONE);
    amp  = tone ? tone_amp : gap_amp;
    ci   = noise_term(x[31:16], amp);
    sq   = noise_term(x[15:0], amp);
    if (tone) begin
      ci    = ci + sine_at(phase + QUARTER_TURN);
      sq    = sq + sine_at(phase);
      phase = phase + ((s.symbol_kind == KIND_ZERO) ? step_zero : step_one);
    end
    r.i_byte = quantise(ci);
    r.q_byte = quantise(sq);
    return r;
  endfunction

  function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    case (idx)
      REG_TONE_STEP_ZERO: step_zero = d;
      REG_TONE_STEP_ONE:  step_one  = d;
      REG_GAP_NOISE_AMP:  gap_amp   = d[15:0];
      REG_TONE_NOISE_AMP: tone_amp  = d[15:0];
      REG_OUTPUT_GAIN:    gain      = d[15:0];
      REG_NOISE_SEED: begin
        seed_reg = d;
        lfsr     = (d != 32'd0) ? d : FALLBACK_SEED;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] reg_readback(logic [CFG_IDX_W-1:0] idx);
    case (idx)
      REG_TONE_STEP_ZERO: return step_zero;
      REG_TONE_STEP_ONE:  return step_one;
      REG_GAP_NOISE_AMP:  return {16'd0, gap_amp};
      REG_TONE_NOISE_AMP: return {16'd0, tone_amp};
      REG_OUTPUT_GAIN:    return {16'd0, gain};
      REG_NOISE_SEED:     return seed_reg;
      default:            return '0;
    endcase
  endfunction

  task automatic flag(string what, logic [31:0] want, logic [31:0] got);
    if (fail_count < REPORT_MAX) begin
      $display("%0t: %s: expected %0h, got %0h", $realtime, what, want, got);
    end
    fail_count++;
    mismatches <= fail_count;
  endtask

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Track register traffic, check results against the oldest prediction, queue new ones
  always @(posedge clk) begin : track
    iq_t want;
    if (rst) begin
      step_zero = 32'd53687;
      step_one  = 32'd536871;
      gap_amp   = 16'd6554;
      tone_amp  = 16'd3277;
      gain      = 16'd4096;
      seed_reg  = FALLBACK_SEED;
      lfsr      = FALLBACK_SEED;
      phase     = '0;
      pending_iq.delete();
      outstanding <= 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          apply_write(paddr[PADDR_W-1:2], pwdata);
        end else if (prdata !== reg_readback(paddr[PADDR_W-1:2])) begin
          flag("register read", reg_readback(paddr[PADDR_W-1:2]), prdata);
        end
      end
      if (iq_valid && !iq_stall) begin
        if (pending_iq.size() == 0) begin
          flag("result with no request pending", '0, {16'd0, iq});
        end else begin
          want = pending_iq.pop_front();
          if (iq.i_byte !== want.i_byte) begin
            flag("i_byte", want.i_byte, iq.i_byte);
          end
          if (iq.q_byte !== want.q_byte) begin
            flag("q_byte", want.q_byte, iq.q_byte);
          end
        end
      end
      if (sample_valid && !sample_stall) begin
        pending_iq.push_back(next_iq(sample));
      end
      outstanding <= pending_iq.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the FSK I/Q generator testbench: clock, reset, requests, register traffic
// and verdict. Depends on fskiq_pkg, fsk_iq_sample_generator and fskiq_checker.
module tb_top;
  import fskiq_pkg::*;

  localparam int                   QUIET_LIMIT     = 4000;
  localparam int                   RANDOM_PHASES   = 8;
  localparam int                   ITEMS_PER_PHASE = 240;
  localparam int                   CALM_PHASE      = 3;
  localparam int                   SETTLE_CYCLES   = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE       = 3'd6;
  localparam logic [1:0]           KIND_UNUSED     = 2'd3;

  logic               clk;
  logic               rst;
  logic               sample_valid;
  logic               sample_stall;
  sample_t            sample;
  logic               iq_valid;
  logic               iq_stall = 1'b0;
  iq_t                iq;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  int                 mismatches;
  int                 outstanding;
  logic               calm = 1'b0;
  int                 quiet_cycles = 0;

  fsk_iq_sample_generator uut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .iq_valid     (iq_valid),
    .iq_stall     (iq_stall),
    .iq           (iq),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  fskiq_checker iq_scoreboard (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .iq_valid     (iq_valid),
    .iq_stall     (iq_stall),
    .iq           (iq),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stall results now and then, except during the calm stretch
  always @(posedge clk) begin
    iq_stall <= !calm && ($urandom_range(99) < 9);
  end

  // Abort when nothing moves on any port for too long
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (iq_valid && !iq_stall) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Setup then access phase, then psel and penable drop back to idle on the bus
  task automatic reg_access(input logic wr, input logic [CFG_IDX_W-1:0] idx,
                            input logic [31:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
    reg_access(1'b1, idx, d);
  endtask

  task automatic read_all_regs();
    for (int r = REG_TONE_STEP_ZERO; r <= REG_NOISE_SEED; r++) begin
      reg_access(1'b0, CFG_IDX_W'(r), '0);
    end
  endtask

  // Offer one request, idling now and then, and hold it until taken
  task automatic send_sample(input logic [1:0] kind, input logic rs);
    while (!calm && $urandom_range(99) < 9) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid       <= 1'b1;
    sample.symbol_kind <= kind;
    sample.restart     <= rs;
    do @(posedge clk); while (sample_stall);
  endtask

  // Stop requests and wait for every prediction to be matched
  task automatic drain();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic random_setup();
    logic [31:0] g;
    reg_write(REG_TONE_STEP_ZERO,
              ($urandom_range(3) == 0) ? $urandom : $urandom_range(2000000));
    reg_write(REG_TONE_STEP_ONE,
              ($urandom_range(3) == 0) ? $urandom : $urandom_range(20000000));
    reg_write(REG_GAP_NOISE_AMP, $urandom_range(65535));
    reg_write(REG_TONE_NOISE_AMP, $urandom_range(65535));
    g = $urandom_range(1) ? $urandom_range(8192, 2048) : $urandom_range(65535);
    reg_write(REG_OUTPUT_GAIN, g);
    reg_write(REG_NOISE_SEED, ($urandom_range(15) == 0) ? 32'd0 : $urandom);
  endtask

  // Mostly whole symbols opened by a restart, with a little noise mixed in
  task automatic random_symbols(input int count);
    int         left;
    int         len;
    int         roll;
    logic [1:0] kind;
    logic       rs;
    left = count;
    while (left > 0) begin
      roll = $urandom_range(99);
      if (roll < 45) begin
        kind = KIND_ZERO;
      end else if (roll < 90) begin
        kind = KIND_ONE;
      end else if (roll < 97) begin
        kind = KIND_GAP;
      end else begin
        kind = KIND_UNUSED;
      end
      len = $urandom_range(40, 1);
      for (int k = 0; k < len && left > 0; k++) begin
        rs = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0);
        send_sample(kind, rs);
        left--;
      end
    end
  endtask

  initial begin
    rst          <= 1'b1;
    sample_valid <= 1'b0;
    sample       <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset values, every symbol kind, phase carried across a gap, restart on a gap
    read_all_regs();
    send_sample(KIND_ZERO, 1'b1);
    send_sample(KIND_ZERO, 1'b0);
    send_sample(KIND_ZERO, 1'b0);
    send_sample(KIND_ZERO, 1'b0);
    send_sample(KIND_ONE, 1'b1);
    send_sample(KIND_ONE, 1'b0);
    send_sample(KIND_ONE, 1'b0);
    send_sample(KIND_GAP, 1'b0);
    send_sample(KIND_ONE, 1'b0);
    send_sample(KIND_GAP, 1'b1);
    send_sample(KIND_ONE, 1'b0);
    send_sample(KIND_UNUSED, 1'b0);
    send_sample(KIND_UNUSED, 1'b1);
    drain();

    // All registers at their top values, plus a write past the register list
    reg_write(REG_TONE_STEP_ZERO, 32'hFFFF_FFFF);
    reg_write(REG_TONE_STEP_ONE, 32'hFFFF_FFFF);
    reg_write(REG_GAP_NOISE_AMP, 32'h0000_FFFF);
    reg_write(REG_TONE_NOISE_AMP, 32'h0000_FFFF);
    reg_write(REG_OUTPUT_GAIN, 32'h0000_FFFF);
    reg_write(REG_NOISE_SEED, 32'hFFFF_FFFF);
    reg_write(REG_SPARE, 32'h1234_5678);
    read_all_regs();
    send_sample(KIND_ONE, 1'b1);
    send_sample(KIND_ONE, 1'b0);
    send_sample(KIND_ONE, 1'b0);
    send_sample(KIND_ZERO, 1'b0);
    send_sample(KIND_GAP, 1'b0);
    drain();

    // All zero, including a zero seed that must fall back to the default
    reg_write(REG_TONE_STEP_ZERO, 32'd0);
    reg_write(REG_TONE_STEP_ONE, 32'd0);
    reg_write(REG_GAP_NOISE_AMP, 32'd0);
    reg_write(REG_TONE_NOISE_AMP, 32'd0);
    reg_write(REG_OUTPUT_GAIN, 32'd0);
    reg_write(REG_NOISE_SEED, 32'd0);
    read_all_regs();
    send_sample(KIND_ZERO, 1'b1);
    send_sample(KIND_GAP, 1'b0);
    drain();
    reg_write(REG_OUTPUT_GAIN, 32'h0000_FFFF);
    send_sample(KIND_ZERO, 1'b0);
    send_sample(KIND_ONE, 1'b0);
    send_sample(KIND_GAP, 1'b0);
    drain();

    // Random settings and symbol streams, one phase without any idling
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_setup();
      calm <= (p == CALM_PHASE);
      random_symbols(ITEMS_PER_PHASE);
      drain();
    end

    calm <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
